[src/mtm_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the mutex table.
`timescale 1ns / 1ps

package mtm_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int THREAD_W = 16;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int DEF_PROC_COUNT  = 64;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCK    = 2'd2;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;   // write one zero entry of the clearing pass
        logic load;     // capture the request beat, restart the search
        logic issue;    // read the next table entry
        logic finish;   // commit the table update and capture the answer
        logic push;     // move the answer into the output register
    } mtm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic early_err;
        logic hit;
        logic miss;
    } mtm_stat_t;

endpackage

[src/mtm_dp.sv]
// Datapath of the mutex table: entry memory, search pipeline, update and answer registers.
`timescale 1ns / 1ps

module mtm_dp
    import mtm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH,
    parameter int PROC_COUNT  = DEF_PROC_COUNT,
    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int PW         = $clog2(PROC_COUNT)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mtm_cmd_t            cmd,
    output mtm_stat_t           stat,
    input  logic [OP_W-1:0]     operation,
    input  logic [ID_WIDTH-1:0] lock_id,
    input  logic [PW-1:0]       proc_id,
    input  logic [THREAD_W-1:0] thread_num,
    output logic [STATUS_W-1:0] status,
    output logic [ID_WIDTH-1:0] new_id
);

    localparam int EW = 1 + THREAD_W + PW + ID_WIDTH;

    logic [EW-1:0] mem [TABLE_DEPTH];

    logic [OP_W-1:0]     op_reg;
    logic [ID_WIDTH-1:0] mid_reg;
    logic [PW-1:0]       proc_reg;
    logic [THREAD_W-1:0] thr_reg;
    logic [ID_WIDTH-1:0] next_id_reg;
    logic [AW:0]         addr_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                rd_vld_reg;
    logic [EW-1:0]       rd_data_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ID_WIDTH-1:0] res_new_id_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_WIDTH-1:0] out_new_id_reg;

    logic [ID_WIDTH-1:0] key;
    logic [ID_WIDTH-1:0] w_id;
    logic [PW-1:0]       w_owner;
    logic [THREAD_W-1:0] w_holder;
    logic                w_locked;
    logic                issue_rd;
    logic                proceed;
    logic                upd_we;
    logic [EW-1:0]       upd_word;
    logic [STATUS_W-1:0] res_status;
    logic [ID_WIDTH-1:0] res_new_id;
    logic                alloc_ok;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;

    assign w_id     = rd_data_reg[ID_WIDTH-1:0];
    assign w_owner  = rd_data_reg[ID_WIDTH+PW-1:ID_WIDTH];
    assign w_holder = rd_data_reg[ID_WIDTH+PW+THREAD_W-1:ID_WIDTH+PW];
    assign w_locked = rd_data_reg[EW-1];

    // Alloc looks for a free entry (id zero), the rest for the addressed id
    assign key = (op_reg == OP_ALLOC) ? '0 : mid_reg;

    assign stat.early_err = ({1'b0, proc_reg} >= (PW+1)'(PROC_COUNT))
                          || ((op_reg != OP_ALLOC) && (mid_reg == '0))
                          || ((op_reg == OP_ALLOC) && (next_id_reg == '0));
    assign stat.hit      = rd_vld_reg && (w_id == key);
    assign stat.miss     = rd_vld_reg && (w_id != key)
                          && (rd_idx_reg == AW'(TABLE_DEPTH - 1));
    assign stat.clr_last = (addr_reg == (AW+1)'(TABLE_DEPTH - 1));

    assign issue_rd = cmd.issue && (addr_reg < (AW+1)'(TABLE_DEPTH));
    assign proceed  = stat.hit && !stat.early_err;

    always_comb
    begin
        res_status = ST_ERR;
        res_new_id = '0;
        upd_we     = 1'b0;
        upd_word   = rd_data_reg;
        if (proceed)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    upd_word   = {1'b0, {THREAD_W{1'b0}}, proc_reg, next_id_reg};
                    upd_we     = 1'b1;
                    res_status = ST_OK;
                    res_new_id = next_id_reg;
                end
                OP_DEALLOC:
                begin
                    upd_word   = {1'b0, {THREAD_W{1'b0}}, w_owner, {ID_WIDTH{1'b0}}};
                    upd_we     = 1'b1;
                    res_status = ST_OK;
                end
                OP_LOCK:
                begin
                    if (w_owner != proc_reg || thr_reg == '0)
                        res_status = ST_ERR;
                    else if (w_locked && w_holder == thr_reg)
                        res_status = ST_ERR;
                    else if (w_locked)
                        res_status = ST_BUSY;
                    else
                    begin
                        upd_word   = {1'b1, thr_reg, w_owner, w_id};
                        upd_we     = 1'b1;
                        res_status = ST_OK;
                    end
                end
                OP_UNLOCK:
                begin
                    if (w_owner != proc_reg || !w_locked)
                        res_status = ST_ERR;
                    else
                    begin
                        upd_word   = {1'b0, {THREAD_W{1'b0}}, w_owner, w_id};
                        upd_we     = 1'b1;
                        res_status = ST_OK;
                    end
                end
                default:
                begin
                    res_status = ST_ERR;
                end
            endcase
        end
    end

    assign alloc_ok  = cmd.finish && proceed && (op_reg == OP_ALLOC);
    assign mem_we    = cmd.clr_wr || (cmd.finish && upd_we);
    assign mem_waddr = cmd.clr_wr ? addr_reg[AW-1:0] : rd_idx_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : upd_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (issue_rd)
            rd_data_reg <= mem[addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            next_id_reg <= ID_WIDTH'(1);
        end
        else
        begin
            if (cmd.load)
                addr_reg <= '0;
            else if (cmd.clr_wr || issue_rd)
                addr_reg <= addr_reg + (AW+1)'(1);
            rd_vld_reg <= issue_rd;
            if (issue_rd)
                rd_idx_reg <= addr_reg[AW-1:0];
            if (alloc_ok)
                next_id_reg <= next_id_reg + ID_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            mid_reg  <= lock_id;
            proc_reg <= proc_id;
            thr_reg  <= thread_num;
        end
        if (cmd.finish)
        begin
            res_status_reg <= res_status;
            res_new_id_reg <= res_new_id;
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_new_id_reg <= res_new_id_reg;
        end
    end

    assign status = out_status_reg;
    assign new_id = out_new_id_reg;

`ifndef SYNTH
    a_id_counter_moves_on_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        !alloc_ok |=> $stable(next_id_reg))
        else $error("id counter moved without a successful alloc");

    a_read_pipe_tracks_address: assert property (@(posedge clk) disable iff (!rst_n)
        issue_rd |=> (rd_vld_reg && rd_idx_reg == $past(addr_reg[AW-1:0])))
        else $error("read pipeline lost track of the entry index");

    a_search_starts_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (!rd_vld_reg && addr_reg == '0))
        else $error("search did not restart from the first entry");
`endif

endmodule

[src/mtm_ctrl.sv]
// Controller of the mutex table: clearing pass, request intake, search and answer sequencing.
`timescale 1ns / 1ps

module mtm_ctrl
    import mtm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  mtm_stat_t stat,
    output mtm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   valid_reg;
    logic   valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.early_err || stat.hit || stat.miss)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESP;
                end
                else
                    cmd.issue = 1'b1;
            end
            S_RESP:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        ready_next = (state_next == S_IDLE);
        if (cmd.push)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready_reg;
    assign m_tvalid = valid_reg;

endmodule

[src/mutex_table_manager_core.sv]
// Top level of the mutex lock table: stream ports, beat packing, controller and datapath.
`timescale 1ns / 1ps

// Mutex lock table. Each request beat (alloc, dealloc, lock, unlock) gets one
// answer beat: status (ok, error, busy) and the id handed out by a successful
// alloc. After reset the block runs a clearing pass that marks every entry
// free; s_tready stays low meanwhile. Requests are served one at a time: the
// entry table is a single-port memory searched one entry per cycle, and a
// request ends its search at the first match or after the last entry (a miss,
// also when no entry is free). Requests with a process index of PROC_COUNT or
// more, a zero mutex id (other than alloc) or an exhausted id counter are
// refused without a search. s_tready rises again in the cycle after the answer
// is pushed. The answer sits in an output register, so the next request is
// taken while an earlier answer still waits for m_tready. Ids count up from 1
// and are never reused; once the counter wraps, alloc answers error until
// reset.
module mutex_table_manager_core
    import mtm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH,
    parameter int PROC_COUNT  = DEF_PROC_COUNT,
    localparam int PW         = $clog2(PROC_COUNT),
    localparam int IN_BITS    = OP_W + ID_WIDTH + PW + THREAD_W,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = STATUS_W + ID_WIDTH,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, lock id, proc_id, thread, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, new_id, zero pad
);

    localparam int MID_LO = OP_W;
    localparam int PID_LO = MID_LO + ID_WIDTH;
    localparam int TID_LO = PID_LO + PW;

    mtm_cmd_t            cmd;
    mtm_stat_t           stat;
    logic [STATUS_W-1:0] status;
    logic [ID_WIDTH-1:0] new_id;

    // Sequence the clearing pass, the search and the answer hand-off
    mtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Unpack the request beat straight into the datapath's capture registers
    mtm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .PROC_COUNT  (PROC_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (s_tdata[OP_W-1:0]),
        .lock_id    (s_tdata[PID_LO-1:MID_LO]),
        .proc_id    (s_tdata[TID_LO-1:PID_LO]),
        .thread_num (s_tdata[TID_LO+THREAD_W-1:TID_LO]),
        .status     (status),
        .new_id     (new_id)
    );

    // Pack the answer beat, padding with zeros up to whole bytes
    assign m_tdata = OUT_W'({new_id, status});

endmodule

[tb/mutex_table_manager_core_test.sv]
// Self-checking stream testbench for the mutex lock table core.
`timescale 1ns / 1ps

// Request beats come from a backlog that the stimulus block fills. The driver
// computes each expected answer with an in-bench table predictor when its beat
// is taken. The monitor checks every answer beat against the oldest prediction.
// The run goes through four parts in turn: a directed part, a fill of the
// table to full, random traffic with random stall bursts on both ports, and a
// final stall-free part that frees every entry and runs a short random mix.
module mutex_table_manager_core_test;
    import mtm_pkg::*;

    localparam int TBL_DEPTH  = DEF_TABLE_DEPTH;
    localparam int ID_W       = DEF_ID_WIDTH;
    localparam int PROC_N     = DEF_PROC_COUNT;
    localparam int PROC_W     = $clog2(PROC_N);
    localparam int REQ_W      = 40;
    localparam int ANS_W      = 24;
    localparam int STALL_CAP  = 4000;   // cycles with no beat on either port
    localparam int SETTLE_CYC = 100;    // idle time before the final verdict

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     lock_id;
        logic [PROC_W-1:0]   proc_id;
        logic [THREAD_W-1:0] thread_num;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     new_id;
    } answer_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [REQ_W-1:0] s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [ANS_W-1:0] m_tdata;

    // Predictor copy of the table
    logic [ID_W-1:0]     slot_id     [TBL_DEPTH];
    logic [PROC_W-1:0]   slot_owner  [TBL_DEPTH];
    logic [THREAD_W-1:0] slot_holder [TBL_DEPTH];
    logic                slot_locked [TBL_DEPTH];
    logic [ID_W-1:0]     id_counter;

    request_t request_backlog [$];
    answer_t  due_answers [$];
    request_t beat_on_bus;
    answer_t  oldest_answer;

    int  n_queued      = 0;
    int  n_taken       = 0;
    int  n_bad         = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  send_gap      = 0;
    int  recv_gap      = 0;
    int  quiet_cycles  = 0;
    bit  calm          = 1'b0;

    mutex_table_manager_core #(
        .TABLE_DEPTH (TBL_DEPTH),
        .ID_WIDTH    (ID_W),
        .PROC_COUNT  (PROC_N)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // operation, lock id, proc_id, thread
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // status, new_id, zero pad
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic int find_slot(logic [ID_W-1:0] key);
        for (int k = 0; k < TBL_DEPTH; k++)
            if (slot_id[k] == key)
                return k;
        return -1;
    endfunction

    // Apply one request to the predictor table and return its answer.
    function automatic answer_t serve_request(request_t rq);
        answer_t an;
        int      k;
        an.status = ST_ERR;
        an.new_id = '0;
        if (int'(rq.proc_id) >= PROC_N)
            return an;
        if (rq.op == OP_ALLOC)
        begin
            k = find_slot('0);
            // a wrapped counter means the ids are spent until reset
            if (k >= 0 && id_counter != '0)
            begin
                slot_id[k]     = id_counter;
                slot_owner[k]  = rq.proc_id;
                slot_holder[k] = '0;
                slot_locked[k] = 1'b0;
                an.new_id      = id_counter;
                an.status      = ST_OK;
                id_counter     = id_counter + ID_W'(1);
            end
        end
        else if (rq.lock_id != '0)
        begin
            k = find_slot(rq.lock_id);
            if (k >= 0)
            begin
                if (rq.op == OP_DEALLOC)
                begin
                    // owner is not checked on free; owner field is left stale
                    slot_id[k]     = '0;
                    slot_holder[k] = '0;
                    slot_locked[k] = 1'b0;
                    an.status      = ST_OK;
                end
                else if (slot_owner[k] != rq.proc_id)
                    an.status = ST_ERR;
                else if (rq.op == OP_LOCK)
                begin
                    if (rq.thread_num == '0)
                        an.status = ST_ERR;
                    else if (slot_locked[k] && slot_holder[k] == rq.thread_num)
                        an.status = ST_ERR;
                    else if (slot_locked[k])
                        an.status = ST_BUSY;
                    else
                    begin
                        slot_locked[k] = 1'b1;
                        slot_holder[k] = rq.thread_num;
                        an.status      = ST_OK;
                    end
                end
                else if (slot_locked[k])
                begin
                    // unlock ignores which thread asks
                    slot_locked[k] = 1'b0;
                    slot_holder[k] = '0;
                    an.status      = ST_OK;
                end
            end
        end
        return an;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present backlog beats, predict on each accepted beat
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                due_answers.push_back(serve_request(beat_on_bus));
                n_taken++;
            end
            // load a new beat only once the current one has gone
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (!calm && $urandom_range(0, 99) < send_idle_pct)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= $urandom_range(0, 6);
                end
                else if (request_backlog.size() != 0)
                begin
                    beat_on_bus = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {beat_on_bus.thread_num, beat_on_bus.proc_id,
                                 beat_on_bus.lock_id, beat_on_bus.op};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the answer port in bursts, check each answer beat
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_answers.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("answer beat %h arrived with no request pending", m_tdata);
                end
                else
                begin
                    oldest_answer = due_answers.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== oldest_answer.status ||
                        m_tdata[STATUS_W+ID_W-1:STATUS_W] !== oldest_answer.new_id ||
                        m_tdata[ANS_W-1:STATUS_W+ID_W] !== '0)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"answer mismatch: expected status %0d id %0d,",
                                      " got beat %h (status %0d id %0d)"},
                                     oldest_answer.status, oldest_answer.new_id,
                                     m_tdata, m_tdata[STATUS_W-1:0],
                                     m_tdata[STATUS_W+ID_W-1:STATUS_W]);
                    end
                end
            end
            if (recv_gap != 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!calm && $urandom_range(0, 99) < recv_idle_pct)
            begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 6);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: give up when neither port has moved a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_CAP)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Keep the backlog short so that choices follow the predicted table.
    task automatic post(logic [OP_W-1:0] op, logic [ID_W-1:0] mid,
                        logic [PROC_W-1:0] pr, logic [THREAD_W-1:0] th);
        request_t rq;
        rq.op         = op;
        rq.lock_id    = mid;
        rq.proc_id    = pr;
        rq.thread_num = th;
        while (request_backlog.size() >= 4)
            @(posedge clk);
        request_backlog.push_back(rq);
        n_queued++;
    endtask

    // Hold the sender until every answer owed has come back.
    task automatic settle_table();
        while (request_backlog.size() != 0 || n_taken != n_queued || due_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_live();
        int n;
        int pick;
        n = 0;
        for (int k = 0; k < TBL_DEPTH; k++)
            if (slot_id[k] != '0)
                n++;
        if (n == 0)
            return -1;
        pick = $urandom_range(0, n - 1);
        for (int k = 0; k < TBL_DEPTH; k++)
            if (slot_id[k] != '0)
            begin
                if (pick == 0)
                    return k;
                pick--;
            end
        return -1;
    endfunction

    // About half the time a small thread id (1 to 4), so that relock and busy come up often.
    function automatic logic [THREAD_W-1:0] pick_thread();
        int r;
        r = $urandom_range(0, 99);
        if (r == 0)
            return '0;
        if (r < 50)
            return THREAD_W'($urandom_range(1, 4));
        return THREAD_W'($urandom_range(1, 65535));
    endfunction

    task automatic random_request(int alloc_pct);
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     mid;
        logic [PROC_W-1:0]   pr;
        logic [THREAD_W-1:0] th;
        int                  k;
        int                  r;
        pr = PROC_W'($urandom);
        th = pick_thread();
        if ($urandom_range(0, 99) < alloc_pct)
            post(OP_ALLOC, ID_W'($urandom), pr, th);
        else
        begin
            r  = $urandom_range(0, 99);
            op = (r < 25) ? OP_DEALLOC : (r < 65) ? OP_LOCK : OP_UNLOCK;
            k  = pick_live();
            r  = $urandom_range(0, 99);
            if (k >= 0 && r < 85)
            begin
                // well-formed: a live id, usually from its owner
                mid = slot_id[k];
                if ($urandom_range(0, 99) < 85)
                    pr = slot_owner[k];
                if (op == OP_LOCK && slot_locked[k] && $urandom_range(0, 2) == 0)
                    th = slot_holder[k];
            end
            else if (r < 92)
                mid = ID_W'($urandom);
            else if (r < 96)
                mid = '0;
            else
                mid = ID_W'($urandom_range(1, 300));    // likely stale or never given
            post(op, mid, pr, th);
        end
    endtask

    initial
    begin
        logic [ID_W-1:0] live_ids [$];
        int              alloc_pct;

        for (int k = 0; k < TBL_DEPTH; k++)
        begin
            slot_id[k]     = '0;
            slot_owner[k]  = '0;
            slot_holder[k] = '0;
            slot_locked[k] = 1'b0;
        end
        id_counter = 1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: ids 1 and 2 are handed out first
        send_idle_pct = 20;
        recv_idle_pct = 20;
        post(OP_ALLOC,   16'h0000,  6'd5,  16'd1);
        post(OP_ALLOC,   16'hFFFF,  6'd63, 16'hFFFF);
        post(OP_LOCK,    16'd1,     6'd5,  16'hFFFF);
        post(OP_LOCK,    16'd1,     6'd5,  16'hFFFF);   // relock by holder
        post(OP_LOCK,    16'd1,     6'd5,  16'd7);      // held by another thread
        post(OP_LOCK,    16'd1,     6'd6,  16'd7);      // wrong owner
        post(OP_UNLOCK,  16'd1,     6'd6,  16'd7);      // wrong owner
        post(OP_UNLOCK,  16'd1,     6'd5,  16'd3);      // thread not checked
        post(OP_UNLOCK,  16'd1,     6'd5,  16'd3);      // not locked
        post(OP_LOCK,    16'd1,     6'd5,  16'h0000);   // thread zero
        post(OP_DEALLOC, 16'h0000,  6'd5,  16'd1);      // id zero on every op
        post(OP_LOCK,    16'h0000,  6'd5,  16'd1);
        post(OP_UNLOCK,  16'h0000,  6'd5,  16'd1);
        post(OP_DEALLOC, 16'hFFFF,  6'd0,  16'd1);      // no match
        post(OP_LOCK,    16'hAAAA,  6'd0,  16'h5555);
        post(OP_UNLOCK,  16'h5555,  6'd42, 16'hAAAA);
        post(OP_LOCK,    16'd2,     6'd63, 16'h8001);
        post(OP_DEALLOC, 16'd2,     6'd0,  16'd9);      // free while locked, other process
        post(OP_DEALLOC, 16'd2,     6'd63, 16'd9);      // already free
        post(OP_LOCK,    16'd2,     6'd63, 16'd9);
        post(OP_ALLOC,   16'h1234,  6'd0,  16'd1);      // reuses the lowest free slot
        post(OP_LOCK,    16'd3,     6'd0,  16'd1);

        // Hold until the block has answered everything
        settle_table();

        // Fill the table, then push past full
        for (int i = 0; i < TBL_DEPTH + 2; i++)
            post(OP_ALLOC, ID_W'($urandom), PROC_W'($urandom), pick_thread());

        // Random part in segments of varying mix and back-pressure
        for (int seg = 0; seg < 8; seg++)
        begin
            send_idle_pct = (seg % 4 == 3) ? 0 : $urandom_range(0, 30);
            recv_idle_pct = (seg % 4 == 2) ? 0 : $urandom_range(0, 30);
            alloc_pct     = $urandom_range(10, 60);
            for (int i = 0; i < 100; i++)
                random_request(alloc_pct);
            if ($urandom_range(0, 2) == 0)
                settle_table();
        end

        // Last part: no stalls; free everything, then a short random mix
        settle_table();
        calm = 1'b1;
        for (int k = 0; k < TBL_DEPTH; k++)
            if (slot_id[k] != '0)
                live_ids.push_back(slot_id[k]);
        foreach (live_ids[i])
            post(OP_DEALLOC, live_ids[i], PROC_W'($urandom), pick_thread());
        settle_table();

        for (int i = 0; i < 60; i++)
            random_request(40);

        settle_table();
        repeat (SETTLE_CYC) @(posedge clk);

        if (n_bad == 0 && due_answers.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
src/mtm_pkg.sv
src/mtm_dp.sv
src/mtm_ctrl.sv
src/mutex_table_manager_core.sv
tb/mutex_table_manager_core_test.sv
